@@ src/ps2_mouse_packet_tracker_unit_macros.svh @@
// Assertion macros used by the tracker checker file.
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH

// Assert a property on a named clock, disabled while the reset is low.
`define PMPT_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Assert a property on clk with reset arst_n.
`define PMPT_ASSERT(label, prop, msg) \
	`PMPT_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

@@ src/pmpt_pkg.sv @@
// Package with types and constants of the PS/2 mouse packet tracker.
`default_nettype none

package pmpt_pkg;

	// Widths fixed by the register and field layout
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned CUR_W   = 12;
	localparam int unsigned BYTE_W  = 8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_X_LIMIT    = 2'd0,
		CFG_X_FALLBACK = 2'd1,
		CFG_Y_LIMIT    = 2'd2,
		CFG_Y_FALLBACK = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic [CFG_W-1:0] X_LIMIT_RST    = 12'd320;
	localparam logic [CFG_W-1:0] X_FALLBACK_RST = 12'd315;
	localparam logic [CFG_W-1:0] Y_LIMIT_RST    = 12'd200;
	localparam logic [CFG_W-1:0] Y_FALLBACK_RST = 12'd195;

	// Start position of the cursor after reset
	localparam int unsigned POS_RST = 50;

	// Item kinds
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Byte value that marks the buttons byte when locking the layout
	localparam logic [BYTE_W-1:0] BUTTONS_MARK = 8'h08;

	// Packet layouts
	typedef enum logic [1:0] {
		LAYOUT_UNKNOWN  = 2'd0,
		LAYOUT_BTN_FIRST  = 2'd1,
		LAYOUT_BTN_SECOND = 2'd2
	} layout_t;

	// Position of a byte within a packet
	typedef enum logic [1:0] {
		BYTE_IDX_0 = 2'd0,
		BYTE_IDX_1 = 2'd1,
		BYTE_IDX_2 = 2'd2
	} byte_idx_t;

	// Click codes
	localparam logic [1:0] CLICK_NONE   = 2'd0;
	localparam logic [1:0] CLICK_LEFT   = 2'd1;
	localparam logic [1:0] CLICK_RIGHT  = 2'd2;
	localparam logic [1:0] CLICK_MIDDLE = 2'd3;

	// Configuration register file contents
	typedef struct packed {
		logic [CFG_W-1:0] x_limit;
		logic [CFG_W-1:0] x_fallback;
		logic [CFG_W-1:0] y_limit;
		logic [CFG_W-1:0] y_fallback;
	} cfg_regs_t;

	// One input item
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              from_aux;
	} item_t;

	// One result item
	typedef struct packed {
		logic [CUR_W-1:0] cursor_x;
		logic [CUR_W-1:0] cursor_y;
		logic [1:0]       click_code;
		logic             packet_done;
		logic [1:0]       layout;
	} result_t;

	// Click code from a buttons byte, keeping the old code when no button is down
	function automatic logic [1:0] click_from_buttons(input logic [BYTE_W-1:0] buttons,
			input logic [1:0] old_code);
		logic [1:0] code;
		priority if (buttons[2]) begin
			code = CLICK_MIDDLE;
		end else if (buttons[1]) begin
			code = CLICK_RIGHT;
		end else if (buttons[0]) begin
			code = CLICK_LEFT;
		end else begin
			code = old_code;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

@@ src/pmpt_ifs.sv @@
// Channel interfaces of the PS/2 mouse packet tracker.
`default_nettype none

// Input item channel
interface pmpt_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       from_aux;

	modport source (output valid, output kind, output data_byte, output byte_valid,
		output from_aux, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_valid,
		input from_aux, output ready);
endinterface

// Result item channel
interface pmpt_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] cursor_x;
	logic [11:0] cursor_y;
	logic [1:0]  click_code;
	logic        packet_done;
	logic [1:0]  layout;

	modport source (output valid, output cursor_x, output cursor_y, output click_code,
		output packet_done, output layout, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input click_code,
		input packet_done, input layout, output ready);
endinterface

// Configuration write channel
interface pmpt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ src/pmpt_cfg_regs.sv @@
// Configuration register file of the PS/2 mouse packet tracker.
`default_nettype none

module pmpt_cfg_regs
	import pmpt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_valid,
	output logic            wr_ready,
	input  wire logic [1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	output cfg_regs_t       regs
);

	cfg_regs_t regs_q;

	// Accept a write in every cycle
	assign wr_ready = 1'b1;
	assign regs     = regs_q;

	// Store the written value into the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.x_limit    <= X_LIMIT_RST;
			regs_q.x_fallback <= X_FALLBACK_RST;
			regs_q.y_limit    <= Y_LIMIT_RST;
			regs_q.y_fallback <= Y_FALLBACK_RST;
		end else if (wr_valid) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_X_LIMIT:    regs_q.x_limit    <= wr_data;
				CFG_X_FALLBACK: regs_q.x_fallback <= wr_data;
				CFG_Y_LIMIT:    regs_q.y_limit    <= wr_data;
				CFG_Y_FALLBACK: regs_q.y_fallback <= wr_data;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/pmpt_core.sv @@
// Packet assembly, cursor update and clamp of the PS/2 mouse packet tracker.
`default_nettype none

module pmpt_core
	import pmpt_pkg::*;
#(
	parameter int unsigned POS_WIDTH = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  item_t      item,
	input  cfg_regs_t  regs,
	output result_t    result
);

	// Signed width that holds a position plus a byte delta and any register value
	localparam int unsigned MAX_W = (POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W;
	localparam int unsigned SW    = MAX_W + 2;

	logic [1:0]          byte_index_q;
	logic [BYTE_W-1:0]   first_byte_q;
	logic [BYTE_W-1:0]   second_byte_q;
	layout_t             layout_q;
	logic [POS_WIDTH-1:0] pos_x_q;
	logic [POS_WIDTH-1:0] pos_y_q;
	logic [1:0]          click_q;

	logic                take;
	logic                complete;
	layout_t             layout_next;
	logic                apply;
	logic                btn_first;
	logic [BYTE_W-1:0]   dx_byte;
	logic [BYTE_W-1:0]   buttons;
	logic [1:0]          click_next;
	logic [1:0]          click_out;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] clamp_x;
	logic signed [SW-1:0] clamp_y;

	// Clamp a position: lift to one, snap back above the limit, saturate to the width
	function automatic logic signed [SW-1:0] clamp_pos(input logic signed [SW-1:0] p,
			input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] fallback);
		logic signed [SW-1:0] v;
		logic signed [SW-1:0] one_v;
		logic signed [SW-1:0] lim_v;
		logic signed [SW-1:0] max_v;
		one_v = {{(SW-1){1'b0}}, 1'b1};
		lim_v = {{(SW-CFG_W){1'b0}}, limit};
		max_v = {{(SW-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};
		v = (p < one_v) ? one_v : p;
		if (v > lim_v) begin
			v = {{(SW-CFG_W){1'b0}}, fallback};
		end
		if (v > max_v) begin
			v = max_v;
		end
		return v;
	endfunction

	// Decode the byte, lock the layout and pick delta and buttons bytes
	always_comb begin
		take     = (item.kind == KIND_BYTE) && item.byte_valid && item.from_aux;
		complete = take && (byte_index_q == BYTE_IDX_2);

		layout_next = layout_q;
		if (complete && (layout_q == LAYOUT_UNKNOWN)) begin
			priority if (first_byte_q == BUTTONS_MARK) begin
				layout_next = LAYOUT_BTN_FIRST;
			end else if (second_byte_q == BUTTONS_MARK) begin
				layout_next = LAYOUT_BTN_SECOND;
			end else begin
				layout_next = LAYOUT_UNKNOWN;
			end
		end

		apply     = complete && (layout_next != LAYOUT_UNKNOWN);
		btn_first = (layout_next == LAYOUT_BTN_FIRST);
		dx_byte   = btn_first ? second_byte_q : first_byte_q;
		buttons   = btn_first ? first_byte_q : second_byte_q;
	end

	// Update the click code; a clear reports the old code
	always_comb begin
		if (item.kind == KIND_CLEAR) begin
			click_next = CLICK_NONE;
			click_out  = click_q;
		end else begin
			click_next = apply ? click_from_buttons(buttons, click_q) : click_q;
			click_out  = click_next;
		end
	end

	// Add the deltas and clamp both positions
	always_comb begin
		sum_x = $signed({{(SW-POS_WIDTH){1'b0}}, pos_x_q});
		sum_y = $signed({{(SW-POS_WIDTH){1'b0}}, pos_y_q});
		if (apply) begin
			sum_x = sum_x + $signed({{(SW-BYTE_W){dx_byte[BYTE_W-1]}}, dx_byte});
			sum_y = sum_y + $signed({{(SW-BYTE_W){item.data_byte[BYTE_W-1]}},
				item.data_byte});
		end
		clamp_x = clamp_pos(sum_x, regs.x_limit, regs.x_fallback);
		clamp_y = clamp_pos(sum_y, regs.y_limit, regs.y_fallback);
	end

	// Drive the result of this item
	always_comb begin
		result.cursor_x    = clamp_x[CUR_W-1:0];
		result.cursor_y    = clamp_y[CUR_W-1:0];
		result.click_code  = click_out;
		result.packet_done = complete;
		result.layout      = layout_next;
	end

	// Advance the tracker state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= BYTE_IDX_0;
			first_byte_q  <= '0;
			second_byte_q <= '0;
			layout_q      <= LAYOUT_UNKNOWN;
			pos_x_q       <= POS_WIDTH'(POS_RST);
			pos_y_q       <= POS_WIDTH'(POS_RST);
			click_q       <= CLICK_NONE;
		end else if (step) begin
			if (take) begin
				unique case (byte_index_q)
					BYTE_IDX_1: begin
						second_byte_q <= item.data_byte;
						byte_index_q  <= BYTE_IDX_2;
					end
					BYTE_IDX_2: begin
						byte_index_q <= BYTE_IDX_0;
					end
					default: begin
						first_byte_q <= item.data_byte;
						byte_index_q <= BYTE_IDX_1;
					end
				endcase
			end
			layout_q <= layout_next;
			pos_x_q  <= clamp_x[POS_WIDTH-1:0];
			pos_y_q  <= clamp_y[POS_WIDTH-1:0];
			click_q  <= click_next;
		end
	end

endmodule

`default_nettype wire

@@ src/ps2_mouse_packet_tracker_unit.sv @@
// An item passes the input register and then the result register before its result is offered.
// Throughput: one item per cycle while results are taken; the per-byte update is one short pass between the registers.
// The input register keeps taking items while a result waits, until both registers are full.
// Reset (arst_n low, asynchronous): cursor at 50,50, layout unknown, click code none,
// registers at 320, 315, 200, 195; no clearing pass, items are taken right after reset.
`default_nettype none

module ps2_mouse_packet_tracker_unit
	import pmpt_pkg::*;
#(
	parameter int unsigned POS_WIDTH = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pmpt_in_if.sink   in,
	pmpt_out_if.source out,
	pmpt_cfg_if.sink  cfg
);

	cfg_regs_t regs;
	item_t     item_s1;
	logic      valid_s1;
	result_t   result_c;
	result_t   result_s2;
	logic      valid_s2;
	logic      adv_s1;
	logic      load_s2;

	// Configuration registers
	pmpt_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.regs     (regs)
	);

	// Handshake: the result register frees on a transfer, the input register behind it
	assign load_s2  = !valid_s2 || out.ready;
	assign adv_s1   = valid_s1 && load_s2;
	assign in.ready = !valid_s1 || load_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			item_s1.kind       <= in.kind;
			item_s1.data_byte  <= in.data_byte;
			item_s1.byte_valid <= in.byte_valid;
			item_s1.from_aux   <= in.from_aux;
		end
	end

	// Tracker update
	pmpt_core #(
		.POS_WIDTH (POS_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.regs   (regs),
		.result (result_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_c;
		end
	end

	assign out.valid       = valid_s2;
	assign out.cursor_x    = result_s2.cursor_x;
	assign out.cursor_y    = result_s2.cursor_y;
	assign out.click_code  = result_s2.click_code;
	assign out.packet_done = result_s2.packet_done;
	assign out.layout      = result_s2.layout;

endmodule

`default_nettype wire

@@ src/pmpt_checker.sv @@
// Port checker of the PS/2 mouse packet tracker and its bind.
`default_nettype none
`include "ps2_mouse_packet_tracker_unit_macros.svh"

module pmpt_checker
	import pmpt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] out_cursor_x,
	input wire logic [11:0] out_cursor_y,
	input wire logic [1:0]  out_layout,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	logic       out_fire;
	logic       seen_q;
	logic [1:0] last_layout_q;

	assign out_fire = out_valid && out_ready;

	// Track the layout of the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			last_layout_q <= LAYOUT_UNKNOWN;
		end else if (out_fire) begin
			seen_q        <= 1'b1;
			last_layout_q <= out_layout;
		end
	end

	// A stalled result holds
	`PMPT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y) && $stable(out_layout), "stalled result changed")

	// Input stalls only while a result waits
	`PMPT_ASSERT(a_in_stall, in_valid && !in_ready |-> out_valid, "input stalled with empty output")

	// A locked layout never changes
	`PMPT_ASSERT(a_layout_lock, out_fire && seen_q && (last_layout_q != LAYOUT_UNKNOWN) |-> out_layout == last_layout_q, "locked layout changed")

	// Configuration writes are never stalled
	`PMPT_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind ps2_mouse_packet_tracker_unit pmpt_checker u_pmpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in.valid),
	.in_ready     (in.ready),
	.out_valid    (out.valid),
	.out_ready    (out.ready),
	.out_cursor_x (out.cursor_x),
	.out_cursor_y (out.cursor_y),
	.out_layout   (out.layout),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);

`default_nettype wire
